FILE: design/assert_macros.svh
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset
`define TPCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication: cons must hold in the same cycle as ante
`define TPCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define TPCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tpcc_pkg.sv
// Types, constants and time arithmetic for the two-player game clock
`timescale 1ns / 1ps

package tpcc_pkg;

  localparam logic [6:0] HOURS_MAX = 7'd99;
  localparam logic [5:0] SEXA_MAX  = 6'd59;
  localparam logic [6:0] SEXA_BASE = 7'd60;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_END_MOVE = 2'd1,
    OP_LOAD     = 2'd2,
    OP_START    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_INC_MIN_FIRST  = 2'd0,
    CFG_INC_SEC_FIRST  = 2'd1,
    CFG_INC_MIN_SECOND = 2'd2,
    CFG_INC_SEC_SECOND = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] mins;
    logic [5:0] secs;
  } time_t;

  function automatic logic [5:0] clamp59(input logic [5:0] v);
    return (v > SEXA_MAX) ? SEXA_MAX : v;
  endfunction

  function automatic logic at_zero(input time_t t);
    return (t.hours == '0) && (t.mins == '0) && (t.secs == '0);
  endfunction

  // One second off, borrowing across fields; holds at zero
  function automatic time_t count_down(input time_t t);
    time_t r;
    r = t;
    if (at_zero(t)) begin
      r = t;
    end else if (t.secs != '0) begin
      r.secs = t.secs - 6'd1;
    end else if (t.mins != '0) begin
      r.mins = t.mins - 6'd1;
      r.secs = SEXA_MAX;
    end else begin
      r.hours = t.hours - 7'd1;
      r.mins  = SEXA_MAX;
      r.secs  = SEXA_MAX;
    end
    return r;
  endfunction

  // Base-60 add of minutes and seconds, saturating at HOURS_MAX:59:59
  function automatic time_t add_increment(input time_t t, input logic [5:0] im,
                                          input logic [5:0] is);
    logic [6:0] s;
    logic [6:0] m;
    logic [7:0] h;
    time_t      r;
    s = {1'b0, t.secs} + {1'b0, is};
    m = {1'b0, t.mins} + {1'b0, im};
    h = {1'b0, t.hours};
    if (s >= SEXA_BASE) begin
      s = s - SEXA_BASE;
      m = m + 7'd1;
    end
    if (m >= SEXA_BASE) begin
      m = m - SEXA_BASE;
      h = h + 8'd1;
    end
    if (h > {1'b0, HOURS_MAX}) begin
      r.hours = HOURS_MAX;
      r.mins  = SEXA_MAX;
      r.secs  = SEXA_MAX;
    end else begin
      r.hours = h[6:0];
      r.mins  = m[5:0];
      r.secs  = s[5:0];
    end
    return r;
  endfunction

  function automatic time_t load_time(input logic [6:0] h, input logic [5:0] m,
                                      input logic [5:0] s);
    time_t r;
    r.hours = (h > HOURS_MAX) ? HOURS_MAX : h;
    r.mins  = clamp59(m);
    r.secs  = clamp59(s);
    return r;
  endfunction

endpackage

FILE: design/two_player_countdown_clock_increment.sv
// Two-player game clock with per-move increment, top level
// An accepted input word's result word is registered and shown in the next cycle.
// Takes one word per cycle while the input is not stalled; the clock state doubles as the result register.
// Input stalls only while a result word waits and the output is stalled.
// Reset: both times 0:00:00, first player active, paused, increments zero.
`timescale 1ns / 1ps

module two_player_countdown_clock_increment (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic       player_i,
  input  logic       run_i,
  input  logic [6:0] load_hours_i,
  input  logic [5:0] load_mins_i,
  input  logic [5:0] load_secs_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] first_hours_o,
  output logic [5:0] first_mins_o,
  output logic [5:0] first_secs_o,
  output logic [6:0] second_hours_o,
  output logic [5:0] second_mins_o,
  output logic [5:0] second_secs_o,
  output logic       active_side_o,
  output logic       is_running_o,
  output logic       first_flag_o,
  output logic       second_flag_o
);
  import tpcc_pkg::*;

  logic [5:0] inc_min_q [2];
  logic [5:0] inc_sec_q [2];

  time_t time_q [2];
  time_t time_d [2];
  logic  side_q, side_d;
  logic  running_q, running_d;
  logic  out_valid_q;
  logic  in_accept;
  time_t cur_time;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_min_q[0] <= '0;
      inc_sec_q[0] <= '0;
      inc_min_q[1] <= '0;
      inc_sec_q[1] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_INC_MIN_FIRST:  inc_min_q[0] <= clamp59(cfg_data_i);
        CFG_INC_SEC_FIRST:  inc_sec_q[0] <= clamp59(cfg_data_i);
        CFG_INC_MIN_SECOND: inc_min_q[1] <= clamp59(cfg_data_i);
        CFG_INC_SEC_SECOND: inc_sec_q[1] <= clamp59(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The state registers are the result word; they only move when the
  // output slot is empty or being drained this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cur_time   = time_q[side_q];

  always_comb begin
    time_d[0] = time_q[0];
    time_d[1] = time_q[1];
    side_d    = side_q;
    running_d = running_q;
    unique case (op_e'(op_i))
      OP_TICK: begin
        if (running_q) begin
          time_d[side_q] = count_down(cur_time);
        end
      end
      OP_END_MOVE: begin
        // flagged player gets no increment and keeps the move
        if (running_q && !at_zero(cur_time)) begin
          time_d[side_q] = add_increment(cur_time, inc_min_q[side_q], inc_sec_q[side_q]);
          side_d         = !side_q;
        end
      end
      OP_LOAD: begin
        time_d[player_i] = load_time(load_hours_i, load_mins_i, load_secs_i);
      end
      OP_START: begin
        side_d    = player_i;
        running_d = run_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q[0]   <= '0;
      time_q[1]   <= '0;
      side_q      <= 1'b0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        time_q[0] <= time_d[0];
        time_q[1] <= time_d[1];
        side_q    <= side_d;
        running_q <= running_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_hours_o  = time_q[0].hours;
  assign first_mins_o   = time_q[0].mins;
  assign first_secs_o   = time_q[0].secs;
  assign second_hours_o = time_q[1].hours;
  assign second_mins_o  = time_q[1].mins;
  assign second_secs_o  = time_q[1].secs;
  assign active_side_o  = side_q;
  assign is_running_o   = running_q;
  assign first_flag_o   = at_zero(time_q[0]);
  assign second_flag_o  = at_zero(time_q[1]);

endmodule

FILE: design/tpcc_checker.sv
// Port-level checks for the game clock, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] first_hours_o,
  input logic [5:0] first_mins_o,
  input logic [5:0] first_secs_o,
  input logic [6:0] second_hours_o,
  input logic [5:0] second_mins_o,
  input logic [5:0] second_secs_o,
  input logic       first_flag_o,
  input logic       second_flag_o
);
  import tpcc_pkg::*;

  logic first_zero;
  logic second_zero;

  assign first_zero  = (first_hours_o == '0) && (first_mins_o == '0) && (first_secs_o == '0);
  assign second_zero = (second_hours_o == '0) && (second_mins_o == '0) && (second_secs_o == '0);

  // flags track the shown times
  `TPCC_ASSERT(a_flags_match, (first_flag_o == first_zero) && (second_flag_o == second_zero), "flag does not match time")

  // minutes and seconds stay below sixty
  `TPCC_ASSERT_IMPL(a_sexa_range, out_valid_o, (first_mins_o <= SEXA_MAX) && (first_secs_o <= SEXA_MAX) && (second_mins_o <= SEXA_MAX) && (second_secs_o <= SEXA_MAX), "minutes or seconds out of range")

  // input only backs up behind a waiting result word
  `TPCC_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled with output free")

  // an accepted word always yields a result word next cycle
  `TPCC_ASSERT_NEXT(a_accept_result, in_valid_i && !in_stall_o, out_valid_o, "accepted word gave no result")

  // a stalled result word stays valid and keeps its hours and seconds
  `TPCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(first_hours_o) && $stable(first_secs_o) && $stable(second_hours_o) && $stable(second_secs_o), "stalled result changed")

endmodule

bind two_player_countdown_clock_increment tpcc_checker u_tpcc_checker (.*);
